>>> rtl/core/uvep_pkg.sv
// Shared types and constants for the unit vector to equirectangular pixel block.
package uvep_pkg;

    // Angle accumulator width, units of 2^-32 turn
    localparam int ANG_W = 35;
    // Fraction width after the multiply, 2^-32 units
    localparam int UFRAC_W = 32;
    // Unsigned fraction width, holds 0 .. 2^32
    localparam int U_W = UFRAC_W + 1;
    // CORDIC operand prescale shift
    localparam int PRESCALE_SH = 16;

    // Configuration register indexes
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    // Control that travels beside each item through the cell chain
    typedef struct packed {
        logic valid;
        logic pole;
    } t_ctl;

endpackage

>>> rtl/core/uvep_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per stage.
module uvep_sqrt_cell #(
    parameter int NW = 33,
    parameter int RW = 15,
    parameter int K  = 14
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_ce,
    input  uvep_pkg::t_ctl       i_ctl,
    input  logic signed [15:0]   i_x,
    input  logic signed [15:0]   i_y,
    input  logic signed [15:0]   i_z,
    input  logic [NW-1:0]        i_rem,
    input  logic [RW-1:0]        i_root,
    output uvep_pkg::t_ctl       o_ctl,
    output logic signed [15:0]   o_x,
    output logic signed [15:0]   o_y,
    output logic signed [15:0]   o_z,
    output logic [NW-1:0]        o_rem,
    output logic [RW-1:0]        o_root
);

    logic [NW-1:0] trial;
    logic [NW-1:0] n_rem;
    logic [RW-1:0] n_root;

    // Try setting this bit: remainder must cover 2*root*2^K + 2^2K
    always_comb begin
        trial  = (NW'(i_root) << (K + 1)) + (NW'(1) << (2 * K));
        n_rem  = i_rem;
        n_root = i_root;
        if (i_rem >= trial) begin
            n_rem  = i_rem - trial;
            n_root = i_root | (RW'(1) << K);
        end
    end

    // Advance control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else if (i_ce) begin
            o_ctl <= i_ctl;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            o_x    <= i_x;
            o_y    <= i_y;
            o_z    <= i_z;
            o_rem  <= n_rem;
            o_root <= n_root;
        end
    end

endmodule

>>> rtl/core/uvep_cordic_cell.sv
// One CORDIC vectoring cell, two lanes: longitude and colatitude.
module uvep_cordic_cell #(
    parameter int CW = 35,
    parameter int I  = 0
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_ce,
    input  uvep_pkg::t_ctl                   i_ctl,
    input  logic signed [CW-1:0]             i_lx,
    input  logic signed [CW-1:0]             i_ly,
    input  logic signed [uvep_pkg::ANG_W-1:0] i_la,
    input  logic signed [CW-1:0]             i_cx,
    input  logic signed [CW-1:0]             i_cy,
    input  logic signed [uvep_pkg::ANG_W-1:0] i_ca,
    output uvep_pkg::t_ctl                   o_ctl,
    output logic signed [CW-1:0]             o_lx,
    output logic signed [CW-1:0]             o_ly,
    output logic signed [uvep_pkg::ANG_W-1:0] o_la,
    output logic signed [CW-1:0]             o_cx,
    output logic signed [CW-1:0]             o_cy,
    output logic signed [uvep_pkg::ANG_W-1:0] o_ca
);

    localparam logic signed [uvep_pkg::ANG_W-1:0] STEP_ANG =
        uvep_pkg::ANG_W'(uvep_pkg::ATAN_TURNS[I]);

    logic signed [CW-1:0]             n_lx, n_ly, n_cx, n_cy;
    logic signed [uvep_pkg::ANG_W-1:0] n_la, n_ca;

    // Rotate each lane toward y = 0; hold when y is already zero
    always_comb begin
        n_lx = i_lx;
        n_ly = i_ly;
        n_la = i_la;
        if (i_ly > 0) begin
            n_lx = i_lx + (i_ly >>> I);
            n_ly = i_ly - (i_lx >>> I);
            n_la = i_la + STEP_ANG;
        end else if (i_ly < 0) begin
            n_lx = i_lx - (i_ly >>> I);
            n_ly = i_ly + (i_lx >>> I);
            n_la = i_la - STEP_ANG;
        end
        n_cx = i_cx;
        n_cy = i_cy;
        n_ca = i_ca;
        if (i_cy > 0) begin
            n_cx = i_cx + (i_cy >>> I);
            n_cy = i_cy - (i_cx >>> I);
            n_ca = i_ca + STEP_ANG;
        end else if (i_cy < 0) begin
            n_cx = i_cx - (i_cy >>> I);
            n_cy = i_cy + (i_cx >>> I);
            n_ca = i_ca - STEP_ANG;
        end
    end

    // Advance control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else if (i_ce) begin
            o_ctl <= i_ctl;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            o_lx <= n_lx;
            o_ly <= n_ly;
            o_la <= n_la;
            o_cx <= n_cx;
            o_cy <= n_cy;
            o_ca <= n_ca;
        end
    end

endmodule

>>> rtl/core/unit_vector_to_equirect_pixel.sv
// Top level: unit direction vector to equirectangular map pixel coordinates.
//
// Slave stream: one direction per transaction, tdata = {dir_z, dir_y, dir_x},
// each signed with COORD_FRAC_BITS fraction bits. Master stream: one pixel
// coordinate pair per transaction, tdata = {pixel_y, pixel_x} in units of
// 2^-PIXEL_FRAC_BITS pixel, zero-filled to whole bytes.
// The map size is set through the write port (index 0 width, 1 height); write
// it only while no transaction is in flight.
// Throughput: one transaction per cycle while the receiver takes results. The stages
// from input transaction to output valid are: input stage, one square
// root cell per root bit, CORDIC setup, one cell per CORDIC stage, angle
// fold, multiply, round and saturate.
// All stages share one enable: when the output holds an untaken result and the
// receiver stalls, the whole chain holds and s_tready drops the same cycle.
// Reset empties the chain and loads width 4096 and height 2048.
module unit_vector_to_equirect_pixel #(
    parameter int COORD_FRAC_BITS = 14,
    parameter int PIXEL_FRAC_BITS = 8,
    parameter int CORDIC_STAGES   = 16,
    parameter int WIDTH_BITS      = 13
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // dir_x [15:0], dir_y [31:16], dir_z [47:32]
    input  logic [47:0]           i_s_tdata,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // pixel_x [XW-1:0], pixel_y [XW+YW-1:XW], zero fill above
    output logic [((WIDTH_BITS*2+PIXEL_FRAC_BITS*2+8)/8)*8-1:0] o_m_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [WIDTH_BITS:0]   i_cfg_data
);

    localparam int F    = COORD_FRAC_BITS;
    localparam int XW   = WIDTH_BITS + PIXEL_FRAC_BITS + 1;
    localparam int YW   = WIDTH_BITS + PIXEL_FRAC_BITS;
    localparam int DW   = ((XW + YW + 7) / 8) * 8;
    localparam int NW   = 2 * F + 3;
    localparam int RW   = F + 1;
    localparam int CW   = ((F + 2 > 17) ? F + 2 : 17) + uvep_pkg::PRESCALE_SH + 2;
    localparam int AW   = uvep_pkg::ANG_W;
    localparam int UW   = uvep_pkg::U_W;
    localparam int SH   = uvep_pkg::UFRAC_W - PIXEL_FRAC_BITS;
    localparam int PXW  = UW + WIDTH_BITS + 1;
    localparam int PYW  = UW + WIDTH_BITS;
    localparam int VXW  = PXW + 2;
    localparam int VYW  = PYW + 2;
    localparam logic signed [31:0] ONE = 32'sd1 <<< F;
    localparam logic signed [AW-1:0] HALF_TURN = AW'(64'd1 << 31);
    localparam logic signed [AW-1:0] FULL_TURN = AW'(64'd1 << 32);

    // ---------------- configuration ----------------
    logic [WIDTH_BITS:0]   r_width;
    logic [WIDTH_BITS-1:0] r_height;

    // Decode register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= (WIDTH_BITS + 1)'(4096);
            r_height <= WIDTH_BITS'(2048);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                uvep_pkg::REG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                uvep_pkg::REG_IMAGE_HEIGHT: r_height <= i_cfg_data[WIDTH_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Hold the whole chain while an output result waits
    logic ce;
    assign ce         = !(o_m_tvalid && !i_m_tready);
    assign o_s_tready = ce;

    // ---------------- input stage: clamp z, form 1 - z^2 ----------------
    logic signed [15:0] in_x, in_y, in_z, zc;
    logic signed [31:0] z_wide;
    logic [NW-1:0]      rad;
    logic               pole;

    assign in_x   = i_s_tdata[15:0];
    assign in_y   = i_s_tdata[31:16];
    assign in_z   = i_s_tdata[47:32];
    assign z_wide = 32'(in_z);

    always_comb begin
        zc = in_z;
        if (z_wide > ONE) begin
            zc = 16'(ONE);
        end else if (z_wide < -ONE) begin
            zc = 16'(-ONE);
        end
        pole = (32'(zc) == ONE) || (32'(zc) == -ONE);
        rad  = (NW'(1) << (2 * F)) - NW'(unsigned'(32'(zc * zc)));
    end

    uvep_pkg::t_ctl     sq_ctl  [RW+1];
    logic signed [15:0] sq_x    [RW+1];
    logic signed [15:0] sq_y    [RW+1];
    logic signed [15:0] sq_z    [RW+1];
    logic [NW-1:0]      sq_rem  [RW+1];
    logic [RW-1:0]      sq_root [RW+1];

    // Register the input transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            sq_ctl[0] <= '0;
        end else if (ce) begin
            sq_ctl[0].valid <= i_s_tvalid;
            sq_ctl[0].pole  <= pole;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            sq_x[0]    <= in_x;
            sq_y[0]    <= in_y;
            sq_z[0]    <= zc;
            sq_rem[0]  <= rad;
            sq_root[0] <= '0;
        end
    end

    // ---------------- square root chain ----------------
    for (genvar j = 0; j < RW; j++) begin : g_sqrt
        uvep_sqrt_cell #(.NW(NW), .RW(RW), .K(RW - 1 - j)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ce   (ce),
            .i_ctl  (sq_ctl[j]),
            .i_x    (sq_x[j]),
            .i_y    (sq_y[j]),
            .i_z    (sq_z[j]),
            .i_rem  (sq_rem[j]),
            .i_root (sq_root[j]),
            .o_ctl  (sq_ctl[j+1]),
            .o_x    (sq_x[j+1]),
            .o_y    (sq_y[j+1]),
            .o_z    (sq_z[j+1]),
            .o_rem  (sq_rem[j+1]),
            .o_root (sq_root[j+1])
        );
    end

    // ---------------- CORDIC setup ----------------
    uvep_pkg::t_ctl       cd_ctl [CORDIC_STAGES+1];
    logic signed [CW-1:0] cd_lx  [CORDIC_STAGES+1];
    logic signed [CW-1:0] cd_ly  [CORDIC_STAGES+1];
    logic signed [AW-1:0] cd_la  [CORDIC_STAGES+1];
    logic signed [CW-1:0] cd_cx  [CORDIC_STAGES+1];
    logic signed [CW-1:0] cd_cy  [CORDIC_STAGES+1];
    logic signed [AW-1:0] cd_ca  [CORDIC_STAGES+1];

    logic signed [CW-1:0] lx0, ly0, cx0, cy0;
    logic signed [AW-1:0] la0;

    // Prescale and fold the left half plane into the right one
    always_comb begin
        lx0 = CW'(sq_x[RW]) <<< uvep_pkg::PRESCALE_SH;
        ly0 = CW'(sq_y[RW]) <<< uvep_pkg::PRESCALE_SH;
        la0 = '0;
        if (lx0 < 0) begin
            la0 = (ly0 >= 0) ? HALF_TURN : -HALF_TURN;
            lx0 = -lx0;
            ly0 = -ly0;
        end
        cx0 = CW'(sq_z[RW]) <<< uvep_pkg::PRESCALE_SH;
        cy0 = CW'(signed'({1'b0, sq_root[RW]})) <<< uvep_pkg::PRESCALE_SH;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            cd_ctl[0] <= '0;
        end else if (ce) begin
            cd_ctl[0] <= sq_ctl[RW];
        end
    end

    // Colatitude lane: x = z may be negative, fold the same way
    always_ff @(posedge i_clk) begin
        if (ce) begin
            cd_lx[0] <= lx0;
            cd_ly[0] <= ly0;
            cd_la[0] <= la0;
            if (cx0 < 0) begin
                cd_cx[0] <= -cx0;
                cd_cy[0] <= -cy0;
                cd_ca[0] <= (cy0 >= 0) ? HALF_TURN : -HALF_TURN;
            end else begin
                cd_cx[0] <= cx0;
                cd_cy[0] <= cy0;
                cd_ca[0] <= '0;
            end
        end
    end

    // ---------------- CORDIC chain ----------------
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        uvep_cordic_cell #(.CW(CW), .I(i)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ce   (ce),
            .i_ctl  (cd_ctl[i]),
            .i_lx   (cd_lx[i]),
            .i_ly   (cd_ly[i]),
            .i_la   (cd_la[i]),
            .i_cx   (cd_cx[i]),
            .i_cy   (cd_cy[i]),
            .i_ca   (cd_ca[i]),
            .o_ctl  (cd_ctl[i+1]),
            .o_lx   (cd_lx[i+1]),
            .o_ly   (cd_ly[i+1]),
            .o_la   (cd_la[i+1]),
            .o_cx   (cd_cx[i+1]),
            .o_cy   (cd_cy[i+1]),
            .o_ca   (cd_ca[i+1])
        );
    end

    // ---------------- angle fold ----------------
    logic signed [AW-1:0] t_cl, u_s;
    logic signed [AW:0]   p2;
    logic [UW-1:0]        n_u, n_p;
    logic [UW-1:0]        r_u, r_p;
    logic                 r_fold_vld;

    always_comb begin
        t_cl = cd_la[CORDIC_STAGES];
        if (cd_ctl[CORDIC_STAGES].pole) begin
            t_cl = '0;
        end else if (t_cl > HALF_TURN) begin
            t_cl = HALF_TURN;
        end else if (t_cl < -HALF_TURN) begin
            t_cl = -HALF_TURN;
        end
        u_s = (t_cl < 0) ? -t_cl : FULL_TURN - t_cl;
        n_u = u_s[UW-1:0];
        p2  = (AW + 1)'(cd_ca[CORDIC_STAGES]) <<< 1;
        if (p2 > (AW + 1)'(FULL_TURN)) begin
            n_p = UW'(FULL_TURN);
        end else if (p2 < 0) begin
            n_p = '0;
        end else begin
            n_p = p2[UW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold_vld <= 1'b0;
        end else if (ce) begin
            r_fold_vld <= cd_ctl[CORDIC_STAGES].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_u <= n_u;
            r_p <= n_p;
        end
    end

    // ---------------- scale by map size ----------------
    logic [PXW-1:0] r_prod_x;
    logic [PYW-1:0] r_prod_y;
    logic           r_prod_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else if (ce) begin
            r_prod_vld <= r_fold_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_prod_x <= PXW'(r_u) * PXW'(r_width);
            r_prod_y <= PYW'(r_p) * PYW'(r_height);
        end
    end

    // ---------------- offset, round, saturate ----------------
    logic signed [VXW-1:0] vx;
    logic signed [VYW-1:0] vy;
    logic [XW-1:0]         n_px;
    logic [YW-1:0]         n_py;
    logic [XW-1:0]         r_px;
    logic [YW-1:0]         r_py;
    logic                  r_out_vld;

    always_comb begin
        vx = (signed'(VXW'(r_prod_x)) - (VXW'(1) <<< 31) + (VXW'(1) <<< (SH - 1))) >>> SH;
        vy = (signed'(VYW'(r_prod_y)) - (VYW'(1) <<< 31) + (VYW'(1) <<< (SH - 1))) >>> SH;
        if (vx > signed'((VXW'(1) <<< (XW - 1)) - VXW'(1))) begin
            n_px = {1'b0, {(XW - 1){1'b1}}};
        end else if (vx < -signed'(VXW'(1) <<< (XW - 1))) begin
            n_px = {1'b1, {(XW - 1){1'b0}}};
        end else begin
            n_px = vx[XW-1:0];
        end
        if (vy > signed'((VYW'(1) <<< (YW - 1)) - VYW'(1))) begin
            n_py = {1'b0, {(YW - 1){1'b1}}};
        end else if (vy < -signed'(VYW'(1) <<< (YW - 1))) begin
            n_py = {1'b1, {(YW - 1){1'b0}}};
        end else begin
            n_py = vy[YW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (ce) begin
            r_out_vld <= r_prod_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_px <= n_px;
            r_py <= n_py;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = DW'({r_py, r_px});

    // ---------------- assertions ----------------
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("input taken while output stalled");

    a_root_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_ctl[RW].valid |-> (32'(sq_root[RW]) <= ONE))
        else $error("square root above one");

endmodule
